// ----- design/cnd_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cnd_pkg
// Types, codes and character tables for the cpio newc stream deframer.
// ----------------------------------------------------------------------------
package cnd_pkg;

   localparam int HEADER_BYTES = 110;

   // parser phases
   localparam logic [2:0] PH_HDR_PAD  = 3'd0;
   localparam logic [2:0] PH_HEADER   = 3'd1;
   localparam logic [2:0] PH_NAME     = 3'd2;
   localparam logic [2:0] PH_DATA_PAD = 3'd3;
   localparam logic [2:0] PH_DATA     = 3'd4;
   localparam logic [2:0] PH_STOPPED  = 3'd5;

   // byte kinds
   localparam logic [2:0] KIND_HEADER  = 3'd0;
   localparam logic [2:0] KIND_NAME    = 3'd1;
   localparam logic [2:0] KIND_DATA    = 3'd2;
   localparam logic [2:0] KIND_PAD     = 3'd3;
   localparam logic [2:0] KIND_TRAILER = 3'd4;
   localparam logic [2:0] KIND_IGNORED = 3'd5;

   // status codes
   localparam logic [2:0] ST_RUNNING    = 3'd0;
   localparam logic [2:0] ST_TRAILER    = 3'd1;
   localparam logic [2:0] ST_BAD_MAGIC  = 3'd2;
   localparam logic [2:0] ST_TRUNCATED  = 3'd3;
   localparam logic [2:0] ST_UNTERM     = 3'd4;
   localparam logic [2:0] ST_QUIET_END  = 3'd5;

   // header layout
   localparam logic [6:0] MAGIC_LAST    = 7'd5;
   localparam logic [6:0] FILESIZE_LAST = 7'd61;
   localparam logic [6:0] NAMESIZE_LAST = 7'd101;
   localparam logic [6:0] HEADER_LAST   = 7'(HEADER_BYTES - 1);

   // trailer name match tracking
   localparam logic [4:0] TM_NUL_NEXT = 5'd10;
   localparam logic [4:0] TM_MATCHED  = 5'd11;
   localparam logic [4:0] TM_FAILED   = 5'd31;

   typedef struct packed {
      logic [2:0]  byte_kind;
      logic [7:0]  byte_out;
      logic        header_done;
      logic [31:0] file_size;
      logic [31:0] name_length;
      logic        entry_end;
      logic [2:0]  status;
   } result_type;

   function automatic logic [3:0] hex_nibble(input logic [7:0] c);
      logic [3:0] n;
      n = 4'd0;
      if (c >= 8'h30 && c <= 8'h39) begin
         n = 4'(c - 8'h30);
      end else if (c >= 8'h41 && c <= 8'h46) begin
         n = 4'(c - 8'h37);
      end
      return n;
   endfunction

   // "07070" for the first five magic characters
   function automatic logic [7:0] magic_char(input logic [2:0] idx);
      return idx[0] ? 8'h37 : 8'h30;
   endfunction

   // "TRAILER!!!"
   function automatic logic [7:0] trailer_char(input logic [3:0] idx);
      logic [7:0] c;
      case (idx)
         4'd0:    c = 8'h54;
         4'd1:    c = 8'h52;
         4'd2:    c = 8'h41;
         4'd3:    c = 8'h49;
         4'd4:    c = 8'h4C;
         4'd5:    c = 8'h45;
         4'd6:    c = 8'h52;
         default: c = 8'h21;
      endcase
      return c;
   endfunction

endpackage
`default_nettype wire

// ----- design/cpio_newc_stream_deframer.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cpio_newc_stream_deframer
// Parses a cpio newc archive byte stream and tags every byte.
//
// The req_ channel carries one archive byte per transfer, with req_last_byte
// on the final byte of a buffer; the next byte starts a fresh archive.
// The rsp_ channel returns one result per byte: its kind, the byte itself,
// the decoded size fields, header and entry markers, and the parse status.
// A byte goes through an input register, the parse logic and an output
// register: the result is offered from the output register, which loads
// the parse result when the byte in the input register advances.
// One byte is taken every cycle as long as the output is drained; the
// parser state loop (phase, counters, size registers) updates once per byte.
// Under rsp_stall the output register holds, the input register fills,
// and req_stall then rises until the result is taken.
// Reset empties both registers and returns the parser to header padding
// at offset zero, as at the start of a buffer.
// ----------------------------------------------------------------------------
module cpio_newc_stream_deframer #(
   parameter int ALIGN_BYTES = 4
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [7:0]  req_data_byte,
   input  wire logic        req_last_byte,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [2:0]       rsp_byte_kind,
   output logic [7:0]       rsp_byte_out,
   output logic             rsp_header_done,
   output logic [31:0]      rsp_file_size,
   output logic [31:0]      rsp_name_length,
   output logic             rsp_entry_end,
   output logic [2:0]       rsp_status
);

   logic                in_valid_ff, in_valid_in;
   logic [7:0]          in_byte_ff;
   logic                in_last_ff;
   logic                out_valid_ff, out_valid_in;
   cnd_pkg::result_type out_ff;
   cnd_pkg::result_type result;
   logic                advance;
   logic                req_take;
   logic                rsp_take;

   assign advance   = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;
   assign rsp_take  = out_valid_ff && !rsp_stall;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      if (advance) begin
         out_valid_in = 1'b1;
      end else if (rsp_take) begin
         out_valid_in = 1'b0;
      end
   end

   cnd_core #(
      .ALIGN_BYTES (ALIGN_BYTES)
   ) u_core (
      .clock     (clock),
      .reset     (reset),
      .step      (advance),
      .data_byte (in_byte_ff),
      .last_byte (in_last_ff),
      .result    (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_byte_ff <= req_data_byte;
         in_last_ff <= req_last_byte;
      end
      if (advance) begin
         out_ff <= result;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_byte_kind   = out_ff.byte_kind;
   assign rsp_byte_out    = out_ff.byte_out;
   assign rsp_header_done = out_ff.header_done;
   assign rsp_file_size   = out_ff.file_size;
   assign rsp_name_length = out_ff.name_length;
   assign rsp_entry_end   = out_ff.entry_end;
   assign rsp_status      = out_ff.status;

endmodule
`default_nettype wire

// ----- design/cnd_core.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cnd_core
// Parser state and the per-byte next-state logic; one byte per step.
// ----------------------------------------------------------------------------
module cnd_core #(
   parameter int ALIGN_BYTES = 4
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              step,
   input  wire logic [7:0]        data_byte,
   input  wire logic              last_byte,
   output cnd_pkg::result_type    result
);

   localparam int OFS_W = (ALIGN_BYTES > 1) ? $clog2(ALIGN_BYTES) : 1;
   localparam logic [OFS_W:0] ALIGN_CNT = (OFS_W + 1)'(ALIGN_BYTES);

   logic [2:0]       phase_ff, phase_in;
   logic [6:0]       idx_ff, idx_in;
   logic [31:0]      acc_ff, acc_in;
   logic [31:0]      fsize_ff, fsize_in;
   logic [31:0]      nsize_ff, nsize_in;
   logic [31:0]      remain_ff, remain_in;
   logic [OFS_W-1:0] ofs_ff, ofs_in;
   logic             magic_ff, magic_in;
   logic [4:0]       tm_ff, tm_in;
   logic [2:0]       stop_st_ff, stop_st_in;

   logic [2:0]       cur_phase;
   logic [6:0]       cur_idx;
   logic             cur_magic;
   logic [4:0]       cur_tm;
   logic [OFS_W:0]   ofs_inc;
   logic [OFS_W-1:0] ofs_nxt;
   logic [31:0]      remain_dec;
   logic             magic_hit;
   logic [2:0]       kind;
   logic [2:0]       st;
   logic             hdone;
   logic             eend;
   logic             complete;
   logic             stop;

   assign ofs_inc    = {1'b0, ofs_ff} + 1'b1;
   assign ofs_nxt    = (ofs_inc >= ALIGN_CNT) ? '0 : ofs_inc[OFS_W-1:0];
   assign remain_dec = remain_ff - 32'd1;

   // an aligned offset in header padding opens a new header right away
   always_comb begin
      cur_phase = phase_ff;
      cur_idx   = idx_ff;
      cur_magic = magic_ff;
      cur_tm    = tm_ff;
      if (phase_ff == cnd_pkg::PH_HDR_PAD && ofs_ff == '0) begin
         cur_phase = cnd_pkg::PH_HEADER;
         cur_idx   = '0;
         cur_magic = 1'b1;
         cur_tm    = '0;
      end
   end

   always_comb begin
      if (cur_idx == cnd_pkg::MAGIC_LAST) begin
         magic_hit = (data_byte == 8'h31) || (data_byte == 8'h32);
      end else begin
         magic_hit = (data_byte == cnd_pkg::magic_char(cur_idx[2:0]));
      end
   end

   always_comb begin
      phase_in   = phase_ff;
      idx_in     = idx_ff;
      acc_in     = acc_ff;
      fsize_in   = fsize_ff;
      nsize_in   = nsize_ff;
      remain_in  = remain_ff;
      magic_in   = magic_ff;
      tm_in      = tm_ff;
      stop_st_in = stop_st_ff;
      ofs_in     = ofs_nxt;
      kind       = cnd_pkg::KIND_HEADER;
      st         = cnd_pkg::ST_RUNNING;
      hdone      = 1'b0;
      eend       = 1'b0;
      complete   = 1'b0;
      stop       = 1'b0;

      if (phase_ff == cnd_pkg::PH_STOPPED) begin
         kind = cnd_pkg::KIND_IGNORED;
         st   = stop_st_ff;
      end else begin
         phase_in = cur_phase;
         idx_in   = cur_idx;
         magic_in = cur_magic;
         tm_in    = cur_tm;
         unique case (cur_phase)
            cnd_pkg::PH_HDR_PAD: begin
               kind = cnd_pkg::KIND_PAD;
            end
            cnd_pkg::PH_HEADER: begin
               kind = cnd_pkg::KIND_HEADER;
               if (cur_idx <= cnd_pkg::MAGIC_LAST) begin
                  if (!magic_hit) begin
                     magic_in = 1'b0;
                  end
               end else begin
                  acc_in = {acc_ff[27:0], cnd_pkg::hex_nibble(data_byte)};
                  if (cur_idx == cnd_pkg::FILESIZE_LAST) begin
                     fsize_in = acc_in;
                  end
                  if (cur_idx == cnd_pkg::NAMESIZE_LAST) begin
                     nsize_in = acc_in;
                  end
               end
               if (cur_idx >= cnd_pkg::HEADER_LAST) begin
                  hdone = 1'b1;
                  if (!magic_in) begin
                     st   = cnd_pkg::ST_BAD_MAGIC;
                     stop = 1'b1;
                  end else if (nsize_in == '0) begin
                     st   = cnd_pkg::ST_UNTERM;
                     stop = 1'b1;
                  end else begin
                     phase_in  = cnd_pkg::PH_NAME;
                     remain_in = nsize_in;
                     tm_in     = '0;
                  end
               end else begin
                  idx_in = cur_idx + 7'd1;
               end
            end
            cnd_pkg::PH_NAME: begin
               if (cur_tm < cnd_pkg::TM_NUL_NEXT) begin
                  tm_in = (data_byte == cnd_pkg::trailer_char(cur_tm[3:0])) ?
                          cur_tm + 5'd1 : cnd_pkg::TM_FAILED;
               end else if (cur_tm == cnd_pkg::TM_NUL_NEXT) begin
                  tm_in = (data_byte == 8'h00) ? cnd_pkg::TM_MATCHED : cnd_pkg::TM_FAILED;
               end
               kind      = (tm_in == cnd_pkg::TM_MATCHED) ?
                           cnd_pkg::KIND_TRAILER : cnd_pkg::KIND_NAME;
               remain_in = remain_dec;
               if (remain_dec == '0) begin
                  if (data_byte != 8'h00) begin
                     st   = cnd_pkg::ST_UNTERM;
                     stop = 1'b1;
                  end else if (ofs_nxt != '0) begin
                     phase_in = cnd_pkg::PH_DATA_PAD;
                  end else if (fsize_ff != '0) begin
                     phase_in  = cnd_pkg::PH_DATA;
                     remain_in = fsize_ff;
                  end else begin
                     complete = 1'b1;
                  end
               end
            end
            cnd_pkg::PH_DATA_PAD: begin
               kind = (cur_tm == cnd_pkg::TM_MATCHED) ? cnd_pkg::KIND_TRAILER : cnd_pkg::KIND_PAD;
               if (ofs_nxt == '0) begin
                  if (fsize_ff != '0) begin
                     phase_in  = cnd_pkg::PH_DATA;
                     remain_in = fsize_ff;
                  end else begin
                     complete = 1'b1;
                  end
               end
            end
            default: begin
               // file data
               kind = (cur_tm == cnd_pkg::TM_MATCHED) ? cnd_pkg::KIND_TRAILER : cnd_pkg::KIND_DATA;
               remain_in = remain_dec;
               if (remain_dec == '0) begin
                  complete = 1'b1;
               end
            end
         endcase

         if (complete) begin
            if (tm_in == cnd_pkg::TM_MATCHED) begin
               st   = cnd_pkg::ST_TRAILER;
               stop = 1'b1;
            end else begin
               eend     = 1'b1;
               phase_in = cnd_pkg::PH_HDR_PAD;
               if (last_byte) begin
                  st = cnd_pkg::ST_QUIET_END;
               end
            end
         end else if (last_byte && !stop) begin
            st = cnd_pkg::ST_TRUNCATED;
         end
      end

      if (stop) begin
         phase_in   = cnd_pkg::PH_STOPPED;
         stop_st_in = st;
      end

      result.byte_kind   = kind;
      result.byte_out    = data_byte;
      result.header_done = hdone;
      result.file_size   = fsize_in;
      result.name_length = nsize_in;
      result.entry_end   = eend;
      result.status      = st;

      // end of buffer: start over on the next byte
      if (last_byte) begin
         phase_in   = cnd_pkg::PH_HDR_PAD;
         idx_in     = '0;
         acc_in     = '0;
         fsize_in   = '0;
         nsize_in   = '0;
         remain_in  = '0;
         ofs_in     = '0;
         magic_in   = 1'b1;
         tm_in      = '0;
         stop_st_in = cnd_pkg::ST_RUNNING;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= cnd_pkg::PH_HDR_PAD;
         idx_ff     <= '0;
         acc_ff     <= '0;
         fsize_ff   <= '0;
         nsize_ff   <= '0;
         remain_ff  <= '0;
         ofs_ff     <= '0;
         magic_ff   <= 1'b1;
         tm_ff      <= '0;
         stop_st_ff <= cnd_pkg::ST_RUNNING;
      end else if (step) begin
         phase_ff   <= phase_in;
         idx_ff     <= idx_in;
         acc_ff     <= acc_in;
         fsize_ff   <= fsize_in;
         nsize_ff   <= nsize_in;
         remain_ff  <= remain_in;
         ofs_ff     <= ofs_in;
         magic_ff   <= magic_in;
         tm_ff      <= tm_in;
         stop_st_ff <= stop_st_in;
      end
   end

endmodule
`default_nettype wire
